### rtl/core/rgrn_pkg.sv
`timescale 1ns / 1ps
package rgrn_pkg;

  localparam int WIN       = 32;
  localparam int IDX_W     = $clog2(WIN);
  localparam int CNT_W     = $clog2(WIN + 1);
  localparam int HND_W     = 10;
  localparam int SEQ_W     = 16;
  localparam int SID_W     = 32;
  localparam int TIME_W    = 32;
  localparam int MASK_W    = 16;
  localparam int NACK_SPAN = 17;
  localparam int LEFT_W    = IDX_W;

  localparam logic [15:0] WAIT_RESET = 16'd100;

  localparam logic [1:0] FN_ORIG   = 2'd0;
  localparam logic [1:0] FN_REPAIR = 2'd1;
  localparam logic [1:0] FN_TICK   = 2'd2;
  localparam logic [1:0] FN_NONE   = 2'd3;

  localparam logic [1:0] KD_DELIVER = 2'd0;
  localparam logic [1:0] KD_LOST    = 2'd1;
  localparam logic [1:0] KD_NACK    = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_REPAIR_PLACE,
    OP_SET_STREAM,
    OP_TAKE,
    OP_REL_STEP,
    OP_NACK_STEP,
    OP_FINISH
  } op_t;

  typedef enum logic [1:0] {
    TK_DONE,
    TK_EMIT,
    TK_OPEN,
    TK_ABANDON
  } take_cls_t;

  typedef struct packed {
    op_t  op;
    logic force_rel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       stream_chg;
    logic       repair_ok;
    take_cls_t  take_cls;
    logic       rel_act;
    logic       nack_more;
    logic       can_emit;
  } sts_t;

endpackage

### rtl/core/rgrn_ctrl.sv
`timescale 1ns / 1ps
module rgrn_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  rgrn_pkg::sts_t sts,
  output rgrn_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DISP, S_REL, S_STREAM, S_TAKE, S_NACK, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    R_TAKE, R_STREAM, R_FIN
  } ret_t;

  state_t state_r, state_nxt;
  logic   force_r, force_nxt;
  ret_t   ret_r, ret_nxt;
  rgrn_pkg::op_t op;

  assign in_tready     = (state_r == S_IDLE);
  assign cmd.op        = op;
  assign cmd.force_rel = force_r;

  always_comb begin
    state_nxt = state_r;
    force_nxt = force_r;
    ret_nxt   = ret_r;
    op        = rgrn_pkg::OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op        = rgrn_pkg::OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.func)
          rgrn_pkg::FN_ORIG: begin
            if (sts.stream_chg) begin
              force_nxt = 1'b1;
              ret_nxt   = R_STREAM;
              state_nxt = S_REL;
            end else begin
              state_nxt = S_TAKE;
            end
          end
          rgrn_pkg::FN_REPAIR: begin
            if (sts.repair_ok) begin
              op        = rgrn_pkg::OP_REPAIR_PLACE;
              force_nxt = 1'b0;
              ret_nxt   = R_FIN;
              state_nxt = S_REL;
            end else begin
              state_nxt = S_FIN;
            end
          end
          rgrn_pkg::FN_TICK: begin
            force_nxt = 1'b0;
            ret_nxt   = R_FIN;
            state_nxt = S_REL;
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_REL: begin
        if (!sts.rel_act) begin
          case (ret_r)
            R_TAKE:   state_nxt = S_TAKE;
            R_STREAM: state_nxt = S_STREAM;
            default:  state_nxt = S_FIN;
          endcase
        end else if (sts.can_emit) begin
          op = rgrn_pkg::OP_REL_STEP;
        end
      end
      S_STREAM: begin
        op        = rgrn_pkg::OP_SET_STREAM;
        state_nxt = S_TAKE;
      end
      S_TAKE: begin
        if (sts.can_emit) begin
          op = rgrn_pkg::OP_TAKE;
          case (sts.take_cls)
            rgrn_pkg::TK_ABANDON: begin
              force_nxt = 1'b1;
              ret_nxt   = R_TAKE;
              state_nxt = S_REL;
            end
            rgrn_pkg::TK_OPEN: state_nxt = S_NACK;
            default: begin
              force_nxt = 1'b0;
              ret_nxt   = R_FIN;
              state_nxt = S_REL;
            end
          endcase
        end
      end
      S_NACK: begin
        if (!sts.nack_more) begin
          force_nxt = 1'b0;
          ret_nxt   = R_FIN;
          state_nxt = S_REL;
        end else if (sts.can_emit) begin
          op = rgrn_pkg::OP_NACK_STEP;
        end
      end
      S_FIN: begin
        if (sts.can_emit) begin
          op        = rgrn_pkg::OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      force_r <= 1'b0;
      ret_r   <= R_FIN;
    end else begin
      state_r <= state_nxt;
      force_r <= force_nxt;
      ret_r   <= ret_nxt;
    end
  end

endmodule

### rtl/core/rgrn_dp.sv
`timescale 1ns / 1ps
module rgrn_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   in_func,
  input  logic [rgrn_pkg::SID_W-1:0]   in_sid,
  input  logic [rgrn_pkg::SEQ_W-1:0]   in_seq,
  input  logic [rgrn_pkg::HND_W-1:0]   in_handle,
  input  logic                         in_big,
  input  logic [rgrn_pkg::TIME_W-1:0]  in_now,
  input  logic                         cfg_we,
  input  logic [15:0]                  cfg_wait,
  input  rgrn_pkg::cmd_t               cmd,
  output rgrn_pkg::sts_t               sts,
  input  logic                         out_tready,
  output logic                         out_tvalid,
  output logic [1:0]                   out_kind,
  output logic [rgrn_pkg::HND_W-1:0]   out_handle,
  output logic [rgrn_pkg::SEQ_W-1:0]   out_seq,
  output logic [rgrn_pkg::MASK_W-1:0]  out_mask,
  output logic                         out_last
);

  localparam int IW = rgrn_pkg::IDX_W;
  localparam int CW = rgrn_pkg::CNT_W;
  localparam int HW = rgrn_pkg::HND_W;
  localparam int SW = rgrn_pkg::SEQ_W;
  localparam int TW = rgrn_pkg::TIME_W;
  localparam int MW = rgrn_pkg::MASK_W;
  localparam int LW = rgrn_pkg::LEFT_W;
  localparam int NACK_W_C = MW + 1;

  // latched item
  logic [1:0]                 func_r;
  logic [rgrn_pkg::SID_W-1:0] sid_r;
  logic [SW-1:0]              seq_r;
  logic [HW-1:0]              hnd_in_r;
  logic                       big_r;
  logic [TW-1:0]              now_r;

  logic [15:0] wait_r;

  logic                       have_r, have_nxt;
  logic [rgrn_pkg::SID_W-1:0] cur_r, cur_nxt;
  logic [SW-1:0]              exp_r, exp_nxt;
  logic                       gap_r, gap_nxt;
  logic [CW-1:0]              wc_r, wc_nxt;
  logic [TW-1:0]              dl_r, dl_nxt;
  logic [rgrn_pkg::WIN-1:0]   fill_r, fill_nxt;
  logic [HW-1:0]              slot_r [rgrn_pkg::WIN];
  logic [HW-1:0]              slot_nxt [rgrn_pkg::WIN];
  logic [SW-1:0]              nst_r, nst_nxt;
  logic [LW-1:0]              nleft_r, nleft_nxt;

  // staged result and output register
  logic          pend_v_r, pend_v_nxt;
  logic [1:0]    pend_kind_r, pend_kind_nxt;
  logic [HW-1:0] pend_hnd_r, pend_hnd_nxt;
  logic [SW-1:0] pend_seq_r, pend_seq_nxt;
  logic [MW-1:0] pend_mask_r, pend_mask_nxt;
  logic          out_v_r, out_v_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic [HW-1:0] out_hnd_r, out_hnd_nxt;
  logic [SW-1:0] out_seq_r, out_seq_nxt;
  logic [MW-1:0] out_mask_r, out_mask_nxt;
  logic          out_last_r, out_last_nxt;

  logic [SW-1:0] d;
  logic [IW-1:0] idx;
  logic          d_lt_wc, d_eq_wc, d_far, expired, can_emit;
  logic [TW-1:0] tdiff;
  logic [15:0]   wait_eff;
  logic [LW-1:0] chunk;
  logic [NACK_W_C-1:0] mask_full;
  rgrn_pkg::take_cls_t tcls;

  logic          em_v;
  logic [1:0]    em_kind;
  logic [HW-1:0] em_hnd;
  logic [SW-1:0] em_seq;
  logic [MW-1:0] em_mask;

  assign d        = seq_r - exp_r;
  assign idx      = d[IW-1:0];
  assign d_far    = (d[SW-1:IW] != '0);
  assign d_lt_wc  = (d[SW-1:CW] == '0) && (d[CW-1:0] < wc_r);
  assign d_eq_wc  = (d[SW-1:CW] == '0) && (d[CW-1:0] == wc_r);
  assign tdiff    = now_r - dl_r;
  assign expired  = !tdiff[TW-1];
  assign wait_eff = (wait_r == 16'd0) ? 16'd1 : wait_r;
  assign can_emit = !pend_v_r || !out_v_r || out_tready;
  assign chunk    = (nleft_r > LW'(rgrn_pkg::NACK_SPAN)) ? LW'(rgrn_pkg::NACK_SPAN) : nleft_r;
  assign mask_full = (NACK_W_C'(1) << (chunk - LW'(1))) - NACK_W_C'(1);

  always_comb begin
    if (d[SW-1]) begin
      tcls = rgrn_pkg::TK_DONE;
    end else if (!gap_r) begin
      if ((d == '0) || d_far || big_r) tcls = rgrn_pkg::TK_EMIT;
      else                             tcls = rgrn_pkg::TK_OPEN;
    end else if (d_lt_wc) begin
      tcls = rgrn_pkg::TK_DONE;
    end else if (d_eq_wc && (wc_r < CW'(rgrn_pkg::WIN)) && !big_r) begin
      tcls = rgrn_pkg::TK_DONE;
    end else begin
      tcls = rgrn_pkg::TK_ABANDON;
    end
  end

  assign sts.func       = func_r;
  assign sts.stream_chg = !have_r || (sid_r != cur_r);
  assign sts.repair_ok  = have_r && gap_r && (sid_r == cur_r) && !big_r && d_lt_wc
                          && !fill_r[idx];
  assign sts.take_cls   = tcls;
  assign sts.rel_act    = gap_r && (fill_r[0] || cmd.force_rel || expired);
  assign sts.nack_more  = (nleft_r != '0);
  assign sts.can_emit   = can_emit;

  always_comb begin
    have_nxt  = have_r;
    cur_nxt   = cur_r;
    exp_nxt   = exp_r;
    gap_nxt   = gap_r;
    wc_nxt    = wc_r;
    dl_nxt    = dl_r;
    fill_nxt  = fill_r;
    slot_nxt  = slot_r;
    nst_nxt   = nst_r;
    nleft_nxt = nleft_r;
    em_v      = 1'b0;
    em_kind   = rgrn_pkg::KD_DELIVER;
    em_hnd    = '0;
    em_seq    = '0;
    em_mask   = '0;
    case (cmd.op)
      rgrn_pkg::OP_REPAIR_PLACE: begin
        fill_nxt[idx] = 1'b1;
        slot_nxt[idx] = hnd_in_r;
      end
      rgrn_pkg::OP_SET_STREAM: begin
        have_nxt = 1'b1;
        cur_nxt  = sid_r;
        exp_nxt  = seq_r;
      end
      rgrn_pkg::OP_TAKE: begin
        if (!d[SW-1]) begin
          if (!gap_r) begin
            if (d == '0) begin
              em_v    = 1'b1;
              em_hnd  = hnd_in_r;
              em_seq  = seq_r;
              exp_nxt = exp_r + SW'(1);
            end else if (d_far || big_r) begin
              em_v    = 1'b1;
              em_hnd  = hnd_in_r;
              em_seq  = seq_r;
              exp_nxt = seq_r + SW'(1);
            end else begin
              gap_nxt       = 1'b1;
              wc_nxt        = CW'(idx) + CW'(1);
              fill_nxt      = '0;
              fill_nxt[idx] = 1'b1;
              slot_nxt[idx] = hnd_in_r;
              dl_nxt        = now_r + TW'(wait_eff);
              nst_nxt       = exp_r;
              nleft_nxt     = LW'(idx);
            end
          end else if (d_lt_wc) begin
            if (!fill_r[idx] && !big_r) begin
              fill_nxt[idx] = 1'b1;
              slot_nxt[idx] = hnd_in_r;
            end
          end else if (d_eq_wc && (wc_r < CW'(rgrn_pkg::WIN)) && !big_r) begin
            fill_nxt[idx] = 1'b1;
            slot_nxt[idx] = hnd_in_r;
            wc_nxt        = wc_r + CW'(1);
          end
        end
      end
      rgrn_pkg::OP_REL_STEP: begin
        em_v    = 1'b1;
        em_seq  = exp_r;
        if (fill_r[0]) begin
          em_hnd = slot_r[0];
        end else begin
          em_kind = rgrn_pkg::KD_LOST;
        end
        fill_nxt = {1'b0, fill_r[rgrn_pkg::WIN-1:1]};
        for (int i = 0; i < rgrn_pkg::WIN - 1; i++) begin
          slot_nxt[i] = slot_r[i+1];
        end
        wc_nxt  = wc_r - CW'(1);
        exp_nxt = exp_r + SW'(1);
        if (wc_r == CW'(1)) gap_nxt = 1'b0;
      end
      rgrn_pkg::OP_NACK_STEP: begin
        em_v      = 1'b1;
        em_kind   = rgrn_pkg::KD_NACK;
        em_seq    = nst_r;
        em_mask   = mask_full[MW-1:0];
        nst_nxt   = nst_r + SW'(chunk);
        nleft_nxt = nleft_r - chunk;
      end
      default: ;
    endcase
  end

  always_comb begin
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_hnd_nxt  = pend_hnd_r;
    pend_seq_nxt  = pend_seq_r;
    pend_mask_nxt = pend_mask_r;
    out_v_nxt     = out_v_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_hnd_nxt   = out_hnd_r;
    out_seq_nxt   = out_seq_r;
    out_mask_nxt  = out_mask_r;
    out_last_nxt  = out_last_r;
    if ((em_v || (cmd.op == rgrn_pkg::OP_FINISH)) && pend_v_r) begin
      out_v_nxt    = 1'b1;
      out_kind_nxt = pend_kind_r;
      out_hnd_nxt  = pend_hnd_r;
      out_seq_nxt  = pend_seq_r;
      out_mask_nxt = pend_mask_r;
      out_last_nxt = !em_v;
      pend_v_nxt   = 1'b0;
    end
    if (em_v) begin
      pend_v_nxt    = 1'b1;
      pend_kind_nxt = em_kind;
      pend_hnd_nxt  = em_hnd;
      pend_seq_nxt  = em_seq;
      pend_mask_nxt = em_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == rgrn_pkg::OP_LOAD) begin
      func_r   <= in_func;
      sid_r    <= in_sid;
      seq_r    <= in_seq;
      hnd_in_r <= in_handle;
      big_r    <= in_big;
      now_r    <= in_now;
    end
    slot_r      <= slot_nxt;
    nst_r       <= nst_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_hnd_r  <= pend_hnd_nxt;
    pend_seq_r  <= pend_seq_nxt;
    pend_mask_r <= pend_mask_nxt;
    out_kind_r  <= out_kind_nxt;
    out_hnd_r   <= out_hnd_nxt;
    out_seq_r   <= out_seq_nxt;
    out_mask_r  <= out_mask_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r   <= rgrn_pkg::WAIT_RESET;
      have_r   <= 1'b0;
      cur_r    <= '0;
      exp_r    <= '0;
      gap_r    <= 1'b0;
      wc_r     <= '0;
      dl_r     <= '0;
      fill_r   <= '0;
      nleft_r  <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_we) wait_r <= cfg_wait;
      have_r   <= have_nxt;
      cur_r    <= cur_nxt;
      exp_r    <= exp_nxt;
      gap_r    <= gap_nxt;
      wc_r     <= wc_nxt;
      dl_r     <= dl_nxt;
      fill_r   <= fill_nxt;
      nleft_r  <= nleft_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_kind   = out_kind_r;
  assign out_handle = out_hnd_r;
  assign out_seq    = out_seq_r;
  assign out_mask   = out_mask_r;
  assign out_last   = out_last_r;

endmodule

### rtl/core/rtp_gap_reorder_nack.sv
`timescale 1ns / 1ps
// flow: a new item is accepted only in the idle state; its results wait behind any gap that is flushed
//   first; each result is held one step in a staging register so the final one can carry
//   tlast, then sits in the output register
// the controller walks the release and nack loops at one result per cycle while the output
//   is not stalled, with up to 34 release or nack results per item
// reset: synchronous active low; window empty, no stream, wait_ms back to 100
module rtp_gap_reorder_nack (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,  // stream_id, in_seq, in_handle, oversized, now_ms, zero fill
  input  logic [1:0]  in_tuser,  // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata, // out_handle, out_seq, nack_mask, zero fill
  output logic [1:0]  out_tuser, // kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  rgrn_pkg::cmd_t cmd;
  rgrn_pkg::sts_t sts;
  logic [9:0]  o_hnd;
  logic [15:0] o_seq;
  logic [15:0] o_mask;

  assign cfg_ready = 1'b1;

  rgrn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rgrn_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_func    (in_tuser),
    .in_sid     (in_tdata[31:0]),
    .in_seq     (in_tdata[47:32]),
    .in_handle  (in_tdata[57:48]),
    .in_big     (in_tdata[58]),
    .in_now     (in_tdata[90:59]),
    .cfg_we     (cfg_valid),
    .cfg_wait   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_kind   (out_tuser),
    .out_handle (o_hnd),
    .out_seq    (o_seq),
    .out_mask   (o_mask),
    .out_last   (out_tlast)
  );

  assign out_tdata = {6'd0, o_mask, o_seq, o_hnd};

endmodule

### rtl/core/rgrn_checker.sv
`timescale 1ns / 1ps
module rgrn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result after reset");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == rgrn_pkg::KD_DELIVER || out_tuser == rgrn_pkg::KD_LOST
                    || out_tuser == rgrn_pkg::KD_NACK))
    else $error("bad result kind");

  a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != rgrn_pkg::KD_DELIVER |-> out_tdata[9:0] == 10'd0)
    else $error("handle on non-delivery");

  a_mask_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != rgrn_pkg::KD_NACK |-> out_tdata[41:26] == 16'd0)
    else $error("mask on non-nack");

endmodule

bind rtp_gap_reorder_nack rgrn_checker u_rgrn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  typedef struct {
    logic [1:0]  kind;
    logic [9:0]  hnd;
    logic [15:0] seq;
    logic [15:0] mask;
    logic        last;
  } res_t;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] sid;
    logic [15:0] seq;
    logic [9:0]  hnd;
    logic        big;
    logic [31:0] now;
    bit          typed;
    res_t        want;
  } pkt_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  rtp_gap_reorder_nack u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // reorder window shadow
  logic [15:0] wait_reg;
  bit          have_sid;
  logic [31:0] cur_sid;
  logic [15:0] next_seq;
  bit          gap_on;
  int          held;
  logic [31:0] deadline;
  bit          filled [rgrn_pkg::WIN];
  logic [9:0]  slot_hnd [rgrn_pkg::WIN];

  res_t step_res[$];
  res_t pending_res[$];
  int   errors = 0;
  int   idle_cycles = 0;

  function automatic void put_res(logic [1:0] kind, logic [9:0] h, logic [15:0] s,
                                  logic [15:0] m);
    res_t r;
    r.kind = kind; r.hnd = h; r.seq = s; r.mask = m; r.last = 1'b0;
    if (step_res.size() < 34) step_res.push_back(r);
  endfunction

  function automatic void advance_window();
    for (int i = 0; i + 1 < held && i + 1 < rgrn_pkg::WIN; i++) begin
      filled[i] = filled[i + 1];
      slot_hnd[i] = slot_hnd[i + 1];
    end
    if (held > 0) begin
      held--;
      if (held < rgrn_pkg::WIN) filled[held] = 1'b0;
    end
    next_seq = next_seq + 16'd1;
  endfunction

  function automatic void drain_window(logic [31:0] now, bit forced);
    logic [31:0] diff;
    while (gap_on) begin
      diff = now - deadline;
      if (filled[0]) put_res(rgrn_pkg::KD_DELIVER, slot_hnd[0], next_seq, '0);
      else if (forced || !diff[31]) put_res(rgrn_pkg::KD_LOST, '0, next_seq, '0);
      else break;
      advance_window();
      if (held == 0) gap_on = 1'b0;
    end
  endfunction

  function automatic void nack_run(logic [15:0] start, int missing);
    int done = 0;
    int chunk;
    logic [31:0] m;
    while (done < missing) begin
      chunk = missing - done;
      if (chunk > rgrn_pkg::NACK_SPAN) chunk = rgrn_pkg::NACK_SPAN;
      m = (32'd1 << (chunk - 1)) - 32'd1;
      put_res(rgrn_pkg::KD_NACK, '0, start + 16'(done), m[15:0]);
      done += chunk;
    end
  endfunction

  function automatic void take_orig(logic [15:0] s, logic [9:0] h, bit big, logic [31:0] now);
    logic [15:0] d;
    forever begin
      d = s - next_seq;
      if (d[15]) return;
      if (!gap_on) begin
        if (d == 0) begin
          put_res(rgrn_pkg::KD_DELIVER, h, s, '0);
          next_seq = next_seq + 16'd1;
          return;
        end
        if (d >= rgrn_pkg::WIN || big) begin
          next_seq = s + 16'd1;
          put_res(rgrn_pkg::KD_DELIVER, h, s, '0);
          return;
        end
        gap_on = 1'b1;
        held = d + 1;
        foreach (filled[i]) filled[i] = 1'b0;
        filled[d] = 1'b1; slot_hnd[d] = h;
        deadline = now + ((wait_reg == 0) ? 32'd1 : 32'(wait_reg));
        nack_run(next_seq, d);
        return;
      end
      if (d < held) begin
        if (!filled[d] && !big) begin
          filled[d] = 1'b1; slot_hnd[d] = h;
        end
        return;
      end
      if (d == held && held < rgrn_pkg::WIN && !big) begin
        filled[d] = 1'b1; slot_hnd[d] = h;
        held++;
        return;
      end
      drain_window(now, 1'b1);
    end
  endfunction

  function automatic void predict_pkt(pkt_t p);
    logic [15:0] d;
    step_res.delete();
    if (p.func == rgrn_pkg::FN_ORIG) begin
      if (!have_sid || p.sid != cur_sid) begin
        drain_window(p.now, 1'b1);
        have_sid = 1'b1; cur_sid = p.sid; next_seq = p.seq;
      end
      take_orig(p.seq, p.hnd, p.big, p.now);
      drain_window(p.now, 1'b0);
    end else if (p.func == rgrn_pkg::FN_REPAIR) begin
      if (have_sid && gap_on && p.sid == cur_sid && !p.big) begin
        d = p.seq - next_seq;
        if (!d[15] && d < held && d < rgrn_pkg::WIN && !filled[d]) begin
          filled[d] = 1'b1; slot_hnd[d] = p.hnd;
          drain_window(p.now, 1'b0);
        end
      end
    end else if (p.func == rgrn_pkg::FN_TICK) begin
      drain_window(p.now, 1'b0);
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
  endfunction

  task automatic send_pkt(pkt_t p, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= p.func;
    in_tdata <= {5'd0, p.now, p.big, p.hnd, p.seq, p.sid};
    do @(posedge clk); while (!in_tready);
    predict_pkt(p);
    if (p.typed) pending_res.push_back(p.want);
    else foreach (step_res[i]) pending_res.push_back(step_res[i]);
  endtask

  task automatic settle_and_write(logic [15:0] v);
    in_tvalid <= 1'b0;
    while (pending_res.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    wait_reg = v;
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  function automatic pkt_t mk(logic [1:0] f, logic [31:0] sid, logic [15:0] s, logic [9:0] h,
                              logic big, logic [31:0] now);
    pkt_t p;
    p.func = f; p.sid = sid; p.seq = s; p.hnd = h; p.big = big; p.now = now;
    p.typed = 0; p.want = '{default: '0};
    return p;
  endfunction

  function automatic pkt_t mk_typed(pkt_t p, logic [1:0] kind, logic [9:0] h, logic [15:0] s,
                                    logic [15:0] m);
    p.typed = 1;
    p.want = '{kind: kind, hnd: h, seq: s, mask: m, last: 1'b1};
    return p;
  endfunction

  // result sink with random back-pressure
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_res.size() == 0) begin
        $error("unexpected result kind %0d seq %0d", out_tuser, out_tdata[25:10]);
        errors++;
      end else begin
        e = pending_res.pop_front();
        if (out_tuser !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, out_tuser); errors++;
        end
        if (out_tdata[9:0] !== e.hnd) begin
          $error("out_handle exp %0d got %0d", e.hnd, out_tdata[9:0]); errors++;
        end
        if (out_tdata[25:10] !== e.seq) begin
          $error("out_seq exp %0d got %0d", e.seq, out_tdata[25:10]); errors++;
        end
        if (out_tdata[41:26] !== e.mask) begin
          $error("nack_mask exp %h got %h", e.mask, out_tdata[41:26]); errors++;
        end
        if (out_tlast !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_tlast); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("[rtp_gap_reorder_nack] ERROR");
      $finish;
    end
  end

  initial begin
    pkt_t dir[$];
    pkt_t p;
    logic [31:0] g_sid, g_now;
    logic [15:0] g_seq, w;
    int r;
    logic [15:0] phase_wait[5] = '{16'd1, 16'd65535, 16'd0, 16'd20, 16'd300};

    wait_reg = rgrn_pkg::WAIT_RESET;
    have_sid = 0; cur_sid = '0; next_seq = '0; gap_on = 0; held = 0; deadline = '0;
    foreach (filled[i]) begin
      filled[i] = 1'b0; slot_hnd[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir.push_back(mk_typed(mk(rgrn_pkg::FN_ORIG, 32'hA5A5_0001, 16'd100, 10'd5, 0, 32'd0),
                           rgrn_pkg::KD_DELIVER, 10'd5, 16'd100, 16'd0));
    dir.push_back(mk_typed(mk(rgrn_pkg::FN_ORIG, 32'hA5A5_0001, 16'd101, 10'd1023, 0, 32'd1),
                           rgrn_pkg::KD_DELIVER, 10'd1023, 16'd101, 16'd0));
    dir.push_back(mk_typed(mk(rgrn_pkg::FN_ORIG, 32'hA5A5_0001, 16'd104, 10'd7, 0, 32'd10),
                           rgrn_pkg::KD_NACK, 10'd0, 16'd102, 16'd1));
    dir.push_back(mk(rgrn_pkg::FN_REPAIR, 32'hA5A5_0001, 16'd102, 10'd8, 0, 32'd11));
    dir.push_back(mk(rgrn_pkg::FN_REPAIR, 32'hA5A5_0001, 16'd102, 10'd9, 0, 32'd12));
    dir.push_back(mk(rgrn_pkg::FN_REPAIR, 32'hA5A5_0001, 16'd103, 10'd9, 1, 32'd13));
    dir.push_back(mk(rgrn_pkg::FN_ORIG, 32'hA5A5_0001, 16'd50, 10'd3, 0, 32'd14));
    dir.push_back(mk(rgrn_pkg::FN_TICK, 32'd0, 16'd0, 10'd0, 0, 32'd200));
    dir.push_back(mk(rgrn_pkg::FN_TICK, 32'd0, 16'd0, 10'd0, 0, 32'd201));
    dir.push_back(mk(rgrn_pkg::FN_NONE, 32'hFFFF_FFFF, 16'hFFFF, 10'h3FF, 1, 32'hFFFF_FFFF));
    dir.push_back(mk_typed(mk(rgrn_pkg::FN_ORIG, 32'hA5A5_0001, 16'd105, 10'd9, 1, 32'd210),
                           rgrn_pkg::KD_DELIVER, 10'd9, 16'd105, 16'd0));
    dir.push_back(mk_typed(mk(rgrn_pkg::FN_ORIG, 32'hA5A5_0001, 16'd140, 10'd10, 0, 32'd211),
                           rgrn_pkg::KD_DELIVER, 10'd10, 16'd140, 16'd0));
    dir.push_back(mk(rgrn_pkg::FN_ORIG, 32'hA5A5_0001, 16'd150, 10'd11, 0, 32'd212));
    dir.push_back(mk(rgrn_pkg::FN_ORIG, 32'hA5A5_0001, 16'd145, 10'd12, 1, 32'd213));
    dir.push_back(mk(rgrn_pkg::FN_ORIG, 32'hA5A5_0001, 16'd200, 10'd13, 1, 32'd214));
    dir.push_back(mk(rgrn_pkg::FN_ORIG, 32'hA5A5_0001, 16'd232, 10'd14, 0, 32'd215));
    dir.push_back(mk(rgrn_pkg::FN_REPAIR, 32'hA5A5_0002, 16'd201, 10'd15, 0, 32'd216));
    dir.push_back(mk(rgrn_pkg::FN_ORIG, 32'hA5A5_0002, 16'd0, 10'd0, 0, 32'd217));
    dir.push_back(mk(rgrn_pkg::FN_ORIG, 32'hFFFF_FFFF, 16'hFFFF, 10'd0, 0, 32'hFFFF_FFF0));
    dir.push_back(mk(rgrn_pkg::FN_ORIG, 32'hFFFF_FFFF, 16'd2, 10'd1, 0, 32'hFFFF_FFF0));
    dir.push_back(mk(rgrn_pkg::FN_TICK, 32'd0, 16'd0, 10'd0, 0, 32'h0000_0020));
    dir.push_back(mk(rgrn_pkg::FN_REPAIR, 32'hFFFF_FFFF, 16'd1, 10'd2, 0, 32'h0000_0030));
    dir.push_back(mk(rgrn_pkg::FN_TICK, 32'd0, 16'd0, 10'd0, 0, 32'h0000_0060));
    foreach (dir[i]) send_pkt(dir[i], (i % 3 == 0) ? 0 : pick_gap());

    g_sid = $urandom; g_seq = 16'($urandom); g_now = $urandom;
    for (int ph = 0; ph < 5; ph++) begin
      w = (ph == 3) ? 16'($urandom_range(1, 400)) : phase_wait[ph];
      settle_and_write(w);
      for (int k = 0; k < 90; k++) begin
        r = $urandom_range(0, 99);
        g_now = ($urandom_range(0, 49) == 0) ? g_now + $urandom : g_now + $urandom_range(0, 25);
        p = mk(rgrn_pkg::FN_ORIG, g_sid, g_seq, 10'($urandom), ($urandom_range(0, 15) == 0),
               g_now);
        if (r < 55) begin
          if ($urandom_range(0, 4) == 0) p.seq = g_seq + 16'($urandom_range(1, 6));
          g_seq = p.seq + 16'd1;
        end else if (r < 75) begin
          p.func = rgrn_pkg::FN_REPAIR;
          p.seq = g_seq - 16'($urandom_range(1, 12));
          if ($urandom_range(0, 9) == 0) p.sid = $urandom;
        end else if (r < 88) begin
          p.func = rgrn_pkg::FN_TICK;
          p.sid = $urandom; p.seq = 16'($urandom);
        end else if (r < 92) begin
          p.seq = g_seq - 16'($urandom_range(1, 8));
        end else if (r < 95) begin
          p.seq = ($urandom_range(0, 1)) ? g_seq + 16'($urandom_range(20, 40)) : 16'($urandom);
          g_seq = p.seq + 16'd1;
        end else if (r < 98) begin
          g_sid = $urandom; p.sid = g_sid;
          p.seq = 16'($urandom); g_seq = p.seq + 16'd1;
        end else begin
          p.func = rgrn_pkg::FN_NONE;
        end
        send_pkt(p, ($urandom_range(0, 3) == 0) ? 0 : pick_gap());
      end
    end
    settle_and_write(rgrn_pkg::WAIT_RESET);
    for (int k = 0; k < 20; k++) begin
      g_now = g_now + $urandom_range(0, 60);
      p = mk(($urandom_range(0, 3) == 0) ? rgrn_pkg::FN_TICK : rgrn_pkg::FN_ORIG, g_sid, g_seq,
             10'($urandom), 0, g_now);
      if (p.func == rgrn_pkg::FN_ORIG) begin
        if ($urandom_range(0, 2) == 0) p.seq = g_seq + 16'($urandom_range(1, 4));
        g_seq = p.seq + 16'd1;
      end
      send_pkt(p, pick_gap());
    end
    in_tvalid <= 1'b0;
    while (pending_res.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_res.size() == 0) begin
      $display("[rtp_gap_reorder_nack] OK");
    end else begin
      $display("[rtp_gap_reorder_nack] ERROR");
    end
    $finish;
  end

endmodule

### rtp_gap_reorder_nack.f
rtl/core/rgrn_pkg.sv
rtl/core/rgrn_ctrl.sv
rtl/core/rgrn_dp.sv
rtl/core/rtp_gap_reorder_nack.sv
rtl/core/rgrn_checker.sv
verif/tb_top.sv
